/* rtl/rbe_pkg.sv */
// Shared types and constants of the ray/box edge intersection block.
package rbe_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 16;
  localparam int HALF_W  = 15;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic        [HALF_W-1:0]  half_width_x;
    logic        [HALF_W-1:0]  half_width_y;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
  } rsp_t;

endpackage

/* rtl/rbe_intf.sv */
// Valid/ready channel interfaces for queries and results.
interface rbe_req_if;
  logic          valid;
  logic          ready;
  rbe_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbe_rsp_if;
  logic          valid;
  logic          ready;
  rbe_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/ray_box_edge_intersection.sv */
// 2D ray versus axis-aligned box: one face test per item, pipelined, one item per cycle.
//
// Each item carries a ray (Q16.16 origin, fixed-point direction) and a box (center, whole-unit
// half extents). On each axis the face turned toward the origin is taken; the face with the
// larger ray parameter wins (x on a tie), or the only usable one when a direction part is zero.
// A hit needs the face ahead of the origin and its two end points strictly on opposite sides
// of the ray line; all tests are exact cross products, so the direction scale cancels. On a
// hit the face coordinate is reported and the other coordinate is origin plus a
// rounded quotient (ties away from zero), both saturated to 32 bits; a miss reports zeros.
// The pipe takes one item per clock while the output is not stalled. PW is the cross product
// width (50 at COORD_FRAC_BITS = 16). Each item passes the setup, product and face-choice
// stages, one restoring-divider stage per quotient bit, and the output register. The whole
// pipe advances together whenever the output register is empty or being taken.
module ray_box_edge_intersection #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  rbe_req_if.sink        req,
  rbe_rsp_if.source      rsp
);

  localparam int CW   = rbe_pkg::COORD_W;
  localparam int DW   = rbe_pkg::DIR_W;
  localparam int HW_W = rbe_pkg::HALF_W + COORD_FRAC_BITS;      // scaled half extent
  localparam int VW   = ((HW_W + 1 > CW) ? HW_W + 1 : CW) + 1;  // face coordinate
  localparam int NW   = VW + 1;                                 // face minus origin
  localparam int PW   = NW + DW;                                // cross products
  localparam int AW   = PW + 1;                                 // side tests
  localparam int SW   = PW + 2;                                 // final sum
  localparam int QW_STAGES = PW;                                // quotient bits

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // ---- stage 1: capture the item
  logic          v1;
  rbe_pkg::req_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
    if (en) begin
      s1 <= req.data;
    end
  end

  // ---- stage 2: faces and offsets from the origin
  logic signed [VW-1:0] bxe, bye, hwxe, hwye, xlo, xhi, ylo, yhi;
  logic signed [NW-1:0] pxe, pye;

  always_comb begin
    bxe  = VW'(s1.box_x);
    bye  = VW'(s1.box_y);
    hwxe = $signed(VW'({s1.half_width_x, {COORD_FRAC_BITS{1'b0}}}));
    hwye = $signed(VW'({s1.half_width_y, {COORD_FRAC_BITS{1'b0}}}));
    xlo  = bxe - hwxe;
    xhi  = bxe + hwxe;
    ylo  = bye - hwye;
    yhi  = bye + hwye;
    pxe  = NW'(s1.origin_x);
    pye  = NW'(s1.origin_y);
  end

  logic                 v2;
  logic signed [VW-1:0] xval2, yval2;
  logic signed [NW-1:0] nx2, ny2, ex0_2, ex1_2, ey0_2, ey1_2;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [CW-1:0] px2, py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      // origin equal to the center takes the positive face
      xval2 <= (s1.origin_x < s1.box_x) ? xlo : xhi;
      yval2 <= (s1.origin_y < s1.box_y) ? ylo : yhi;
      nx2   <= NW'((s1.origin_x < s1.box_x) ? xlo : xhi) - pxe;
      ny2   <= NW'((s1.origin_y < s1.box_y) ? ylo : yhi) - pye;
      ex0_2 <= NW'(xlo) - pxe;
      ex1_2 <= NW'(xhi) - pxe;
      ey0_2 <= NW'(ylo) - pye;
      ey1_2 <= NW'(yhi) - pye;
      dx2   <= s1.dir_x;
      dy2   <= s1.dir_y;
      px2   <= s1.origin_x;
      py2   <= s1.origin_y;
    end
  end

  // ---- stage 3: cross products
  logic                 v3;
  logic signed [PW-1:0] lhs3, rhs3, px0_3, px1_3, py0_3, py1_3;
  logic                 nx_z3, nx_n3, ny_z3, ny_n3;
  logic signed [VW-1:0] xval3, yval3;
  logic signed [DW-1:0] dx3, dy3;
  logic signed [CW-1:0] px3, py3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      lhs3  <= PW'(nx2) * PW'(dy2);
      rhs3  <= PW'(ny2) * PW'(dx2);
      px0_3 <= PW'(ex0_2) * PW'(dy2);
      px1_3 <= PW'(ex1_2) * PW'(dy2);
      py0_3 <= PW'(ey0_2) * PW'(dx2);
      py1_3 <= PW'(ey1_2) * PW'(dx2);
      nx_z3 <= (nx2 == '0);
      nx_n3 <= nx2[NW-1];
      ny_z3 <= (ny2 == '0);
      ny_n3 <= ny2[NW-1];
      xval3 <= xval2;
      yval3 <= yval2;
      dx3   <= dx2;
      dy3   <= dy2;
      px3   <= px2;
      py3   <= py2;
    end
  end

  // ---- stage 4: face choice and side tests for both faces
  logic dxz, dyz, dxp, dyp, yface_c;

  always_comb begin
    dxz = (dx3 == '0);
    dyz = (dy3 == '0);
    dxp = !dxz && !dx3[DW-1];
    dyp = !dyz && !dy3[DW-1];
    if (dxz) begin
      yface_c = 1'b1;
    end else if (dyz) begin
      yface_c = 1'b0;
    end else if (dxp == dyp) begin
      yface_c = lhs3 < rhs3;
    end else begin
      yface_c = lhs3 > rhs3;
    end
  end

  logic                 v4, yface4, dzero4;
  logic signed [AW-1:0] ay0_4, ay1_4, ax0_4, ax1_4;
  logic signed [PW-1:0] lhs4, rhs4;
  logic                 nx_z4, nx_n4, ny_z4, ny_n4;
  logic signed [VW-1:0] xval4, yval4;
  logic signed [DW-1:0] dx4, dy4;
  logic signed [CW-1:0] px4, py4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      yface4 <= yface_c;
      dzero4 <= dxz && dyz;
      ay0_4  <= AW'(rhs3) - AW'(px0_3);
      ay1_4  <= AW'(rhs3) - AW'(px1_3);
      ax0_4  <= AW'(py0_3) - AW'(lhs3);
      ax1_4  <= AW'(py1_3) - AW'(lhs3);
      lhs4   <= lhs3;
      rhs4   <= rhs3;
      nx_z4  <= nx_z3;
      nx_n4  <= nx_n3;
      ny_z4  <= ny_z3;
      ny_n4  <= ny_n3;
      xval4  <= xval3;
      yval4  <= yval3;
      dx4    <= dx3;
      dy4    <= dy3;
      px4    <= px3;
      py4    <= py3;
    end
  end

  // ---- stage 5: hit test, operand magnitudes, face coordinate
  logic                 n_z, n_n, d_n, hit_c;
  logic signed [AW-1:0] a0, a1;
  logic signed [PW-1:0] num;
  logic signed [DW-1:0] den;
  logic signed [VW-1:0] fval;
  logic signed [CW-1:0] fsat;

  always_comb begin
    n_z   = yface4 ? ny_z4 : nx_z4;
    n_n   = yface4 ? ny_n4 : nx_n4;
    den   = yface4 ? dy4 : dx4;
    d_n   = den[DW-1];
    a0    = yface4 ? ay0_4 : ax0_4;
    a1    = yface4 ? ay1_4 : ax1_4;
    num   = yface4 ? rhs4 : lhs4;
    fval  = yface4 ? yval4 : xval4;
    hit_c = !dzero4 && !n_z && (n_n == d_n) &&
            ((a0[AW-1] && !a1[AW-1] && a1 != '0) ||
             (a1[AW-1] && !a0[AW-1] && a0 != '0));
    if (fval > VW'(rbe_pkg::COORD_MAX)) begin
      fsat = rbe_pkg::COORD_MAX;
    end else if (fval < VW'(rbe_pkg::COORD_MIN)) begin
      fsat = rbe_pkg::COORD_MIN;
    end else begin
      fsat = CW'(fval);
    end
  end

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic                 neg;
    logic                 yface;
    logic signed [CW-1:0] base;
    logic signed [CW-1:0] face;
    logic        [DW-1:0] den;
  } side_t;

  side_t         sd5;
  logic [PW-1:0] nmag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd5.valid <= 1'b0;
    end else if (en) begin
      sd5.valid <= v4;
    end
    if (en) begin
      sd5.hit   <= hit_c;
      sd5.neg   <= num[PW-1] ^ d_n;
      sd5.yface <= yface4;
      sd5.base  <= yface4 ? px4 : py4;
      sd5.face  <= fsat;
      sd5.den   <= d_n ? DW'(-den) : DW'(den);
      nmag5     <= num[PW-1] ? PW'(-num) : PW'(num);
    end
  end

  // ---- stage 6 and divider stages
  side_t         sd [QW_STAGES:0];
  logic [PW-1:0] dq [QW_STAGES:0];
  logic [DW-1:0] rem [QW_STAGES:0];

  // restoring divider, one quotient bit per stage
  logic [DW:0]   trial [QW_STAGES-1:0];
  logic          ge    [QW_STAGES-1:0];

  always_comb begin
    for (int k = 0; k < QW_STAGES; k++) begin
      trial[k] = {rem[k], dq[k][PW-1]};
      ge[k]    = trial[k] >= {1'b0, sd[k].den};
    end
  end

  always_ff @(posedge clk) begin
    // stage 6: bias by half the divisor for round-to-nearest
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      sd[0].valid <= sd5.valid;
    end
    if (en) begin
      sd[0].hit   <= sd5.hit;
      sd[0].neg   <= sd5.neg;
      sd[0].yface <= sd5.yface;
      sd[0].base  <= sd5.base;
      sd[0].face  <= sd5.face;
      sd[0].den   <= sd5.den;
      dq[0]       <= nmag5 + PW'(sd5.den >> 1);
      rem[0]      <= '0;
    end
    for (int k = 0; k < QW_STAGES; k++) begin
      if (rst) begin
        sd[k+1].valid <= 1'b0;
      end else if (en) begin
        sd[k+1].valid <= sd[k].valid;
      end
      if (en) begin
        sd[k+1].hit   <= sd[k].hit;
        sd[k+1].neg   <= sd[k].neg;
        sd[k+1].yface <= sd[k].yface;
        sd[k+1].base  <= sd[k].base;
        sd[k+1].face  <= sd[k].face;
        sd[k+1].den   <= sd[k].den;
        rem[k+1]      <= ge[k] ? DW'(trial[k] - {1'b0, sd[k].den}) : DW'(trial[k]);
        dq[k+1]       <= {dq[k][PW-2:0], ge[k]};
      end
    end
  end

  // ---- output: signed quotient plus origin, saturated
  logic signed [SW-1:0] qs, sum;
  logic signed [CW-1:0] osat;
  side_t                sl;

  always_comb begin
    sl  = sd[QW_STAGES];
    qs  = $signed(SW'(dq[QW_STAGES]));
    if (sl.neg) begin
      qs = -qs;
    end
    sum = qs + SW'(sl.base);
    if (sum > SW'(rbe_pkg::COORD_MAX)) begin
      osat = rbe_pkg::COORD_MAX;
    end else if (sum < SW'(rbe_pkg::COORD_MIN)) begin
      osat = rbe_pkg::COORD_MIN;
    end else begin
      osat = CW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= sl.valid;
    end
    if (en) begin
      rsp.data.hit <= sl.hit;
      if (!sl.hit) begin
        rsp.data.hit_x <= '0;
        rsp.data.hit_y <= '0;
      end else if (sl.yface) begin
        rsp.data.hit_x <= osat;
        rsp.data.hit_y <= sl.face;
      end else begin
        rsp.data.hit_x <= sl.face;
        rsp.data.hit_y <= osat;
      end
    end
  end

endmodule

/* tb/ray_box_edge_intersection_tb.sv */
// Self-checking testbench for the ray/box edge intersection block.
module ray_box_edge_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: predicts the result of each accepted query and checks results in order.
  class hit_scoreboard;
    rbe_pkg::rsp_t pending[$];
    int            errors;

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Quotient rounded to nearest, ties away from zero.
    function longint round_div(longint num, longint den);
      longint a, b, q;
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = (a + b / 2) / b;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function int sgn(longint v);
      return (v > 0) - (v < 0);
    endfunction

    function rbe_pkg::rsp_t predict_hit(rbe_pkg::req_t q);
      longint px, py, dx, dy, bx, by, hwx, hwy, xv, yv, nx, ny;
      longint x0, x1, y0, y1, n, d, a0, a1, hx, hy;
      bit yface;
      rbe_pkg::rsp_t r;
      px = q.origin_x; py = q.origin_y; dx = q.dir_x; dy = q.dir_y;
      bx = q.box_x; by = q.box_y;
      hwx = longint'(q.half_width_x) <<< 16;
      hwy = longint'(q.half_width_y) <<< 16;
      xv = (px < bx) ? bx - hwx : bx + hwx;
      yv = (py < by) ? by - hwy : by + hwy;
      nx = xv - px; ny = yv - py;
      r = '0;
      if (dx == 0 && dy == 0) return r;
      if (dx == 0) yface = 1;
      else if (dy == 0) yface = 0;
      else if ((dx > 0) == (dy > 0)) yface = (nx * dy) < (ny * dx);
      else yface = (nx * dy) > (ny * dx);
      if (yface) begin
        x0 = bx - hwx; x1 = bx + hwx; y0 = yv; y1 = yv; n = ny; d = dy;
      end else begin
        x0 = xv; x1 = xv; y0 = by - hwy; y1 = by + hwy; n = nx; d = dx;
      end
      if (!(sgn(n) != 0 && sgn(n) == sgn(d))) return r;
      a0 = dx * (y0 - py) - dy * (x0 - px);
      a1 = dx * (y1 - py) - dy * (x1 - px);
      if (!((a0 < 0 && a1 > 0) || (a0 > 0 && a1 < 0))) return r;
      if (yface) begin
        hy = sat32(yv); hx = sat32(px + round_div(ny * dx, dy));
      end else begin
        hx = sat32(xv); hy = sat32(py + round_div(nx * dy, dx));
      end
      r.hit = 1'b1;
      r.hit_x = hx[31:0];
      r.hit_y = hy[31:0];
      return r;
    endfunction

    function void note_query(rbe_pkg::req_t q);
      pending.push_back(predict_hit(q));
    endfunction

    function void check_result(rbe_pkg::rsp_t got);
      rbe_pkg::rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.hit_x !== want.hit_x) begin
        $display("%0t: hit_x expected %0d actual %0d", $time, want.hit_x, got.hit_x);
        errors++;
      end
      if (got.hit_y !== want.hit_y) begin
        $display("%0t: hit_y expected %0d actual %0d", $time, want.hit_y, got.hit_y);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  rbe_req_if req_ch();
  rbe_rsp_if rsp_ch();

  ray_box_edge_intersection dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  hit_scoreboard sb;
  bit stim_done;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly zero or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Random coordinate: often small, sometimes anywhere in 32 bits.
  function logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 200) * 32'h10000 - 32'sd100 * 32'h10000;
      default: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
    endcase
  endfunction

  function logic [15:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return 16'($urandom);
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16'sd16384);
    endcase
  endfunction

  // Query aimed near a box so most cases reach the face tests and hits.
  function rbe_pkg::req_t rand_query();
    rbe_pkg::req_t q;
    q.origin_x = rand_coord();
    q.origin_y = rand_coord();
    q.dir_x = rand_dir();
    q.dir_y = rand_dir();
    if ($urandom_range(0, 9) < 8) begin
      q.box_x = q.origin_x + ($signed($urandom_range(0, 40)) - 20) * 32'sh10000
                + $urandom_range(0, 65535);
      q.box_y = q.origin_y + ($signed($urandom_range(0, 40)) - 20) * 32'sh10000
                + $urandom_range(0, 65535);
      q.half_width_x = 15'($urandom_range(0, 12));
      q.half_width_y = 15'($urandom_range(0, 12));
    end else begin
      q.box_x = $urandom;
      q.box_y = $urandom;
      q.half_width_x = 15'($urandom);
      q.half_width_y = 15'($urandom);
    end
    return q;
  endfunction

  // Holds valid through the accepting edge; callers drop it when idling.
  task automatic send_query(rbe_pkg::req_t q);
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_query(q);
  endtask

  task automatic send_gap();
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic mk_send(int ox, int oy, int dx, int dy, int bx, int by, int hx, int hy);
    rbe_pkg::req_t q;
    q.origin_x = ox; q.origin_y = oy; q.dir_x = 16'(dx); q.dir_y = 16'(dy);
    q.box_x = bx; q.box_y = by; q.half_width_x = 15'(hx); q.half_width_y = 15'(hy);
    send_query(q);
  endtask

  // Stimulus process.
  initial begin
    sb = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: plain hits on each face and direction sign
    mk_send(0, 0, 16384, 0, 32'sh50000, 0, 1, 1);
    mk_send(0, 0, -16384, 0, -32'sh50000, 0, 1, 1);
    mk_send(0, 0, 0, 16384, 0, 32'sh50000, 1, 1);
    mk_send(0, 0, 0, -16384, 0, -32'sh50000, 1, 1);
    mk_send(0, 0, 11585, 11585, 32'sh50000, 32'sh60000, 2, 2);
    mk_send(0, 0, -11585, 7000, -32'sh50000, 32'sh30000, 2, 2);
    // zero direction is a miss
    mk_send(0, 0, 0, 0, 32'sh50000, 0, 1, 1);
    // box behind the origin
    mk_send(0, 0, 16384, 0, -32'sh50000, 0, 1, 1);
    // origin coordinate equal to the box center
    mk_send(32'sh50000, 0, 0, 16384, 32'sh50000, 32'sh50000, 1, 1);
    // diagonal ray crossing a face between its end points
    mk_send(0, 0, 16384, 16384, 32'sh50000, 32'sh40000, 1, 1);
    // tie between faces: x face wins
    mk_send(0, 0, 16384, 16384, 32'sh50000, 32'sh50000, 1, 1);
    // zero half widths
    mk_send(0, 0, 16384, 0, 32'sh50000, 0, 0, 0);
    // out-of-range directions and extremes
    mk_send(0, 0, -32768, 32767, -32'sh50000, 32'sh50000, 32767, 32767);
    mk_send(32'h7fffffff, 32'h80000000, -16384, 16384, 0, 0, 32767, 32767);
    mk_send(32'h80000000, 32'h7fffffff, 16384, -16384, 32'h7fffffff, 32'h80000000, 32767, 0);
    // coordinates near the 32-bit limits
    mk_send(32'h7fff0000, 0, 1, 16384, 32'h7fff0000, 32'h7fff0000, 0, 32767);
    mk_send(0, 0, 1, -16384, 0, 32'h80000000, 32767, 0);
    // very small x direction parts
    mk_send(0, 0, 2, 16384, 0, 32'sh10000, 1, 0);
    mk_send(0, 0, -3, 16384, 0, 32'sh30000, 1, 0);
    for (int i = 0; i < 1600; i++) begin
      send_gap();
      // hold off once until the pipe has drained
      if (i == 800) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_query(rand_query());
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls on ready, checked at each taken item.
  initial begin
    int g;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
    end
  end

  // End of run: drain, let the pipe settle, then report.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
rtl/rbe_pkg.sv
rtl/rbe_intf.sv
rtl/ray_box_edge_intersection.sv
tb/ray_box_edge_intersection_tb.sv
